// ----- design/srv_pkg.sv -----
package srv_pkg;

	// Sample, signal and gain formats.
	localparam int SAMPLE_W   = 16;
	localparam int SIG_W      = 24;
	localparam int X_SHIFT    = SIG_W - SAMPLE_W - 1;
	localparam int SUM_W      = SIG_W + 2;
	localparam int SAT_W      = SIG_W + 4;
	localparam int DELAY_W    = 11;
	localparam int GAIN_W     = 15;
	localparam int FRAC       = GAIN_W;
	localparam int OUT_SHIFT  = 9;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;

	// Delay lines: four combs, then two allpasses.
	localparam int LINE_DEPTH_DEF = 2048;
	localparam int COMB_LINES     = 4;
	localparam int AP_LINES       = 2;
	localparam int LINE_NUM       = COMB_LINES + AP_LINES;
	localparam int LINE_IDX_W     = 3;
	localparam int COMB_IDX_W     = 2;
	localparam logic [LINE_IDX_W-1:0] LINE_LAST_COMB = LINE_IDX_W'(COMB_LINES - 1);
	localparam logic [LINE_IDX_W-1:0] LINE_AP_A      = LINE_IDX_W'(COMB_LINES);
	localparam logic [LINE_IDX_W-1:0] LINE_AP_B      = LINE_IDX_W'(COMB_LINES + 1);

	// Digit-serial multiplier: signed signal times unsigned gain.
	localparam int DIGIT_W   = 4;
	localparam int MUL_B_W   = 16;
	localparam int MUL_STEPS = MUL_B_W / DIGIT_W;
	localparam int MUL_CNT_W = $clog2(MUL_STEPS + 1);
	localparam int HI_W      = SIG_W + DIGIT_W + 1;
	localparam int PROD_W    = SIG_W + MUL_B_W + 1;

	// Fixed allpass section.
	localparam logic [MUL_B_W-1:0] AP_GAIN    = MUL_B_W'(22938);
	localparam logic [MUL_B_W-1:0] AP_COMP    = MUL_B_W'(16712);
	localparam logic [DELAY_W-1:0] AP_DELAY_A = DELAY_W'(221);
	localparam logic [DELAY_W-1:0] AP_DELAY_B = DELAY_W'(750);

	// Register reset values.
	localparam logic [DELAY_W-1:0] DELAY_RST [COMB_LINES] = '{
		DELAY_W'(1323), DELAY_W'(1654), DELAY_W'(1786), DELAY_W'(1985)
	};
	localparam logic [GAIN_W-1:0] GAIN_RST [COMB_LINES] = '{
		GAIN_W'(22938), GAIN_W'(21400), GAIN_W'(20900), GAIN_W'(20200)
	};

	// Saturation limits.
	localparam logic signed [SAT_W-1:0] SIG_MAX = SAT_W'((1 << (SIG_W - 1)) - 1);
	localparam logic signed [SAT_W-1:0] SIG_MIN = -SIG_MAX - SAT_W'(1);
	localparam logic signed [SAMPLE_W:0] SMP_MAX = (SAMPLE_W + 1)'((1 << (SAMPLE_W - 1)) - 1);
	localparam logic signed [SAMPLE_W:0] SMP_MIN = -SMP_MAX - (SAMPLE_W + 1)'(1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COMB_DELAY_0 = 3'd0,
		REG_COMB_DELAY_1 = 3'd1,
		REG_COMB_DELAY_2 = 3'd2,
		REG_COMB_DELAY_3 = 3'd3,
		REG_COMB_GAIN_0  = 3'd4,
		REG_COMB_GAIN_1  = 3'd5,
		REG_COMB_GAIN_2  = 3'd6,
		REG_COMB_GAIN_3  = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_LOAD,
		ST_MUL,
		ST_POST,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		OP_COMB,
		OP_AP_FB,
		OP_AP_FF,
		OP_AP_CROSS
	} op_t;

	// Clamp a wide signed value to the 24-bit signal range.
	function automatic logic signed [SIG_W-1:0] sat24(input logic signed [SAT_W-1:0] v);
		if (v > SIG_MAX)
			return SIG_MAX[SIG_W-1:0];
		else if (v < SIG_MIN)
			return SIG_MIN[SIG_W-1:0];
		return v[SIG_W-1:0];
	endfunction

	// Clamp a 17-bit signed value to the 16-bit sample range.
	function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [SAMPLE_W:0] v);
		if (v > SMP_MAX)
			return SMP_MAX[SAMPLE_W-1:0];
		else if (v < SMP_MIN)
			return SMP_MIN[SAMPLE_W-1:0];
		return v[SAMPLE_W-1:0];
	endfunction

endpackage

// ----- design/srv_ram.sv -----
module srv_ram
	import srv_pkg::*;
#(
	parameter int WIDTH = SIG_W,
	parameter int DEPTH = LINE_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule

// ----- design/srv_mul.sv -----
module srv_mul
	import srv_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [SIG_W-1:0]  a,
	input  logic [MUL_B_W-1:0]       b,
	output logic                     busy,
	output logic signed [PROD_W-1:0] product
);

	logic [MUL_CNT_W-1:0]   cnt_q;
	logic signed [SIG_W-1:0] a_q;
	logic [MUL_B_W-1:0]     b_q;
	logic signed [HI_W-1:0] hi_q;
	logic [MUL_B_W-1:0]     lo_q;
	logic signed [HI_W-1:0] digit_prod;
	logic signed [HI_W-1:0] step_s;

	assign busy = (cnt_q != '0);

	// One 4-bit digit of the gain per cycle, least significant first.
	assign digit_prod = a_q * $signed({1'b0, b_q[DIGIT_W-1:0]});
	assign step_s     = hi_q + digit_prod;

	// Low product bits leave the adder one digit a cycle into a shift register.
	assign product = $signed({hi_q[PROD_W-MUL_B_W-1:0], lo_q});

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (start)
			cnt_q <= MUL_CNT_W'(MUL_STEPS);
		else if (busy)
			cnt_q <= cnt_q - 1'b1;
	end

	// Operand and partial product shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			b_q  <= b;
			hi_q <= '0;
			lo_q <= '0;
		end else if (busy) begin
			hi_q <= step_s >>> DIGIT_W;
			lo_q <= {step_s[DIGIT_W-1:0], lo_q[MUL_B_W-1:DIGIT_W]};
			b_q  <= b_q >> DIGIT_W;
		end
	end

endmodule

// ----- design/srv_line.sv -----
module srv_line
	import srv_pkg::*;
#(
	parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [LINE_IDX_W-1:0]         sel,
	input  logic [$clog2(LINE_DEPTH)-1:0] delay,
	input  logic                          advance,
	output logic [$clog2(LINE_DEPTH)-1:0] rd_pos,
	output logic [$clog2(LINE_DEPTH)-1:0] wr_pos
);

	localparam int PW = $clog2(LINE_DEPTH);

	logic [PW-1:0] pos_q [LINE_NUM];

	// The line reads at its position and writes one place behind it,
	// wrapping to the delay when the position is at the start.
	assign rd_pos = pos_q[sel];
	assign wr_pos = (rd_pos == '0) ? delay : rd_pos - 1'b1;

	// Position update; a position at or beyond the delay wraps to zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LINE_NUM; i++)
				pos_q[i] <= '0;
		end else if (advance) begin
			pos_q[sel] <= (rd_pos >= delay) ? '0 : rd_pos + 1'b1;
		end
	end

endmodule

// ----- design/schroeder_reverb_core.sv -----
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_stall    left_sample, right_sample (16-bit signed)
// output    out        out_valid / out_stall  wet_sample (16-bit signed)
// config    in         cfg_we                 cfg_index (3 bits), cfg_data (15 bits)
//
// Each sample is worked on in turn: per delay line a read state, a load state that starts
// the single shared multiplier, a wait in the multiply state and a post state that uses
// the product; ten products in all, each four digit steps. A finish state then loads the
// output register, and the idle state takes the next request.
// After reset the delay stores are cleared one word a cycle, over all 4 * LINE_DEPTH comb
// words (8192 at the default depth); no request is taken until then.
// A finished result waits in the output register while out_stall is high; the next
// request is already taken and worked on, and only its final step waits for room.
module schroeder_reverb_core
	import srv_pkg::*;
#(
	parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] left_sample,
	input  logic signed [SAMPLE_W-1:0] right_sample,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] wet_sample,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data
);

	localparam int PW         = $clog2(LINE_DEPTH);
	localparam int COMB_DEPTH = COMB_LINES * LINE_DEPTH;
	localparam int AP_DEPTH   = AP_LINES * LINE_DEPTH;
	localparam int CAW        = $clog2(COMB_DEPTH);
	localparam int AAW        = $clog2(AP_DEPTH);
	localparam int CW         = (PW > DELAY_W) ? PW : DELAY_W;
	localparam logic [CW-1:0] MAX_DELAY = CW'(LINE_DEPTH - 1);

	// Control state.
	state_t                  state_q, state_d;
	op_t                     op_q;
	logic [LINE_IDX_W-1:0]   line_q;
	logic [CAW-1:0]          clr_q;
	logic                    out_valid_q;
	logic [DELAY_W-1:0]      delay_q [COMB_LINES];
	logic [GAIN_W-1:0]       gain_q  [COMB_LINES];

	// Datapath registers.
	logic signed [SIG_W-1:0]    x_q, t_q, y_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic signed [PROD_W-1:0]   acc_q;
	logic signed [SAMPLE_W-1:0] wet_q;

	// Combinational signals.
	logic                       is_comb;
	logic                       accept;
	logic                       out_load;
	logic [COMB_IDX_W-1:0]      comb_idx;
	logic [DELAY_W-1:0]         raw_delay;
	logic [CW-1:0]              raw_ext;
	logic [PW-1:0]              line_delay;
	logic [PW-1:0]              rd_pos, wr_pos;
	logic                       advance;
	logic [CAW-1:0]             comb_base;
	logic [AAW-1:0]             ap_base;
	logic                       comb_rd_en, comb_wr_en;
	logic [CAW-1:0]             comb_rd_addr, comb_wr_addr;
	logic [SIG_W-1:0]           comb_wr_data, comb_rd_data;
	logic                       ap_rd_en, ap_wr_en;
	logic [AAW-1:0]             ap_rd_addr, ap_wr_addr;
	logic [SIG_W-1:0]           ap_wr_data, ap_rd_data;
	logic signed [SIG_W-1:0]    rd_y;
	logic                       mul_start, mul_busy;
	logic signed [SIG_W-1:0]    mul_a;
	logic [MUL_B_W-1:0]         mul_b;
	logic signed [PROD_W-1:0]   mul_p;
	logic signed [SAMPLE_W:0]   lr_sum;
	logic signed [SIG_W-1:0]    x_new;
	logic signed [PROD_W-FRAC-1:0] rnd_p;
	logic signed [SIG_W-1:0]    fb_add;
	logic signed [SAT_W-1:0]    fb_sum;
	logic signed [SIG_W-1:0]    fb_w;
	logic signed [PROD_W-1:0]   ap_diff;
	logic signed [SIG_W-1:0]    ap_out;
	logic signed [SUM_W-1:0]    sum_nxt;
	logic signed [SUM_W-1:0]    fin_v;
	logic signed [SAMPLE_W:0]   fin_f;

	assign accept    = in_valid && !in_stall;
	assign is_comb   = (line_q < LINE_IDX_W'(COMB_LINES));
	assign comb_idx  = line_q[COMB_IDX_W-1:0];
	assign out_valid = out_valid_q;
	assign wet_sample = wet_q;

	// Delay of the current line, held below the line depth.
	always_comb begin
		if (is_comb)
			raw_delay = delay_q[comb_idx];
		else if (line_q == LINE_AP_A)
			raw_delay = AP_DELAY_A;
		else
			raw_delay = AP_DELAY_B;
		raw_ext    = CW'(raw_delay);
		line_delay = PW'((raw_ext > MAX_DELAY) ? MAX_DELAY : raw_ext);
	end

	// Store addresses: each line owns one block of LINE_DEPTH words.
	assign comb_base    = CAW'(comb_idx) * CAW'(LINE_DEPTH);
	assign ap_base      = (line_q == LINE_AP_B) ? AAW'(LINE_DEPTH) : '0;
	assign comb_rd_addr = comb_base + CAW'(rd_pos);
	assign ap_rd_addr   = ap_base + AAW'(rd_pos);
	assign rd_y         = is_comb ? $signed(comb_rd_data) : $signed(ap_rd_data);

	// Mono input, 7 fraction bits.
	assign lr_sum = (SAMPLE_W + 1)'(left_sample) + (SAMPLE_W + 1)'(right_sample);
	assign x_new  = {lr_sum, {X_SHIFT{1'b0}}};

	// Feedback word: rounded product plus the line input, rounding by bit 14.
	assign rnd_p  = $signed(mul_p[PROD_W-1:FRAC]);
	assign fb_add = (op_q == OP_COMB) ? x_q : t_q;
	assign fb_sum = SAT_W'(rnd_p) + SAT_W'(fb_add) + SAT_W'({1'b0, mul_p[FRAC-1]});
	assign fb_w   = sat24(fb_sum);

	// Allpass output: the held product already carries the rounding half.
	assign ap_diff = acc_q - mul_p;
	assign ap_out  = sat24(SAT_W'($signed(ap_diff[PROD_W-1:FRAC])));

	// Comb output sum.
	assign sum_nxt = sum_q + SUM_W'(y_q);

	// Final mix: the wet signal plus twice the dry signal, rounded and scaled to 16 bits.
	assign fin_v = SUM_W'(t_q) + SUM_W'($signed({x_q, 1'b0}))
		+ SUM_W'(1 << (OUT_SHIFT - 1));
	assign fin_f = fin_v[SUM_W-1:OUT_SHIFT];

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == CAW'(COMB_DEPTH - 1))
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid)
					state_d = ST_READ;
			end
			ST_READ: state_d = ST_LOAD;
			ST_LOAD: state_d = ST_MUL;
			ST_MUL: begin
				if (!mul_busy)
					state_d = ST_POST;
			end
			ST_POST: begin
				case (op_q)
					OP_COMB:     state_d = ST_READ;
					OP_AP_FB:    state_d = ST_MUL;
					OP_AP_FF:    state_d = ST_MUL;
					OP_AP_CROSS: state_d = (line_q == LINE_AP_B) ? ST_FINISH : ST_READ;
					default:     state_d = ST_READ;
				endcase
			end
			ST_FINISH: begin
				if (out_load)
					state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		in_stall     = 1'b1;
		comb_rd_en   = 1'b0;
		ap_rd_en     = 1'b0;
		comb_wr_en   = 1'b0;
		ap_wr_en     = 1'b0;
		comb_wr_addr = comb_base + CAW'(wr_pos);
		ap_wr_addr   = ap_base + AAW'(wr_pos);
		comb_wr_data = fb_w;
		ap_wr_data   = fb_w;
		advance      = 1'b0;
		mul_start    = 1'b0;
		mul_a        = y_q;
		mul_b        = AP_GAIN;
		out_load     = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				comb_wr_en   = 1'b1;
				comb_wr_addr = clr_q;
				comb_wr_data = '0;
				ap_wr_en     = (clr_q < CAW'(AP_DEPTH));
				ap_wr_addr   = AAW'(clr_q);
				ap_wr_data   = '0;
			end
			ST_IDLE: in_stall = 1'b0;
			ST_READ: begin
				comb_rd_en = is_comb;
				ap_rd_en   = !is_comb;
			end
			ST_LOAD: begin
				mul_start = 1'b1;
				mul_a     = rd_y;
				mul_b     = is_comb ? MUL_B_W'(gain_q[comb_idx]) : AP_GAIN;
			end
			ST_MUL: ;
			ST_POST: begin
				case (op_q)
					OP_COMB: begin
						comb_wr_en = 1'b1;
						advance    = 1'b1;
					end
					OP_AP_FB: begin
						ap_wr_en  = 1'b1;
						advance   = 1'b1;
						mul_start = 1'b1;
						mul_a     = y_q;
						mul_b     = AP_COMP;
					end
					OP_AP_FF: begin
						mul_start = 1'b1;
						mul_a     = t_q;
						mul_b     = AP_GAIN;
					end
					OP_AP_CROSS: ;
					default: ;
				endcase
			end
			ST_FINISH: out_load = !out_valid_q || !out_stall;
			default: ;
		endcase
	end

	// Sequencer registers and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			op_q        <= OP_COMB;
			line_q      <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR)
				clr_q <= clr_q + 1'b1;
			if (accept)
				line_q <= '0;
			if (state_q == ST_LOAD)
				op_q <= is_comb ? OP_COMB : OP_AP_FB;
			if (state_q == ST_POST) begin
				case (op_q)
					OP_COMB:     line_q <= line_q + 1'b1;
					OP_AP_FB:    op_q <= OP_AP_FF;
					OP_AP_FF:    op_q <= OP_AP_CROSS;
					OP_AP_CROSS: begin
						if (line_q != LINE_AP_B)
							line_q <= line_q + 1'b1;
					end
					default: ;
				endcase
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < COMB_LINES; i++) begin
				delay_q[i] <= DELAY_RST[i];
				gain_q[i]  <= GAIN_RST[i];
			end
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_COMB_DELAY_0: delay_q[0] <= cfg_data[DELAY_W-1:0];
				REG_COMB_DELAY_1: delay_q[1] <= cfg_data[DELAY_W-1:0];
				REG_COMB_DELAY_2: delay_q[2] <= cfg_data[DELAY_W-1:0];
				REG_COMB_DELAY_3: delay_q[3] <= cfg_data[DELAY_W-1:0];
				REG_COMB_GAIN_0:  gain_q[0]  <= cfg_data[GAIN_W-1:0];
				REG_COMB_GAIN_1:  gain_q[1]  <= cfg_data[GAIN_W-1:0];
				REG_COMB_GAIN_2:  gain_q[2]  <= cfg_data[GAIN_W-1:0];
				REG_COMB_GAIN_3:  gain_q[3]  <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q   <= x_new;
			sum_q <= '0;
		end
		if (state_q == ST_LOAD)
			y_q <= rd_y;
		if (state_q == ST_POST) begin
			case (op_q)
				OP_COMB: begin
					sum_q <= sum_nxt;
					if (line_q == LINE_LAST_COMB)
						t_q <= sat24(SAT_W'(sum_nxt));
				end
				OP_AP_FF:    acc_q <= mul_p + PROD_W'(1 << (FRAC - 1));
				OP_AP_CROSS: t_q <= ap_out;
				default: ;
			endcase
		end
		if (out_load)
			wet_q <= sat16(fin_f);
	end

	srv_line #(
		.LINE_DEPTH(LINE_DEPTH)
	) u_line (
		.clk     (clk),
		.arst_n  (arst_n),
		.sel     (line_q),
		.delay   (line_delay),
		.advance (advance),
		.rd_pos  (rd_pos),
		.wr_pos  (wr_pos)
	);

	srv_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.busy    (mul_busy),
		.product (mul_p)
	);

	srv_ram #(
		.WIDTH(SIG_W),
		.DEPTH(COMB_DEPTH)
	) u_comb_ram (
		.clk     (clk),
		.wr_en   (comb_wr_en),
		.wr_addr (comb_wr_addr),
		.wr_data (comb_wr_data),
		.rd_en   (comb_rd_en),
		.rd_addr (comb_rd_addr),
		.rd_data (comb_rd_data)
	);

	srv_ram #(
		.WIDTH(SIG_W),
		.DEPTH(AP_DEPTH)
	) u_ap_ram (
		.clk     (clk),
		.wr_en   (ap_wr_en),
		.wr_addr (ap_wr_addr),
		.wr_data (ap_wr_data),
		.rd_en   (ap_rd_en),
		.rd_addr (ap_rd_addr),
		.rd_data (ap_rd_data)
	);

endmodule

// ----- design/srv_checker.sv -----
module srv_checker
	import srv_pkg::*;
(
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic signed [SAMPLE_W-1:0] wet_sample
);

	// A taken request keeps the input side closed while it is worked on.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
	else $error("input taken again right after a request");

	// A request is not finished early: the input side is still closed later in its work.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> ##4 in_stall)
	else $error("request finished too early");

	// A new result only appears while the block was busy with a request.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
	else $error("result appeared while the block was idle");

	// A result that is held back stays and does not change.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(wet_sample))
	else $error("stalled result changed or vanished");

endmodule

bind schroeder_reverb_core srv_checker u_srv_checker (.*);
